FILE: rtl/ppls_pkg.sv
// Shared types and constants of the Phong point light shader.
// No dependencies; every other file of the block imports this package.
`default_nettype none
package ppls_pkg;

	// Fixed-point formats that do not follow the color fraction width
	localparam int INTEN_FRAC = 12;
	localparam int EFF_W      = 21;
	localparam int MAG_W      = 30;
	localparam int LEN_W      = 31;
	localparam int SUM_W      = 62;
	localparam int ACC_W      = 40;
	localparam int SHINY_W    = 10;
	localparam int OUT_W      = 15;

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_LIGHT_POS_X = 3'd0,
		REG_LIGHT_POS_Y = 3'd1,
		REG_LIGHT_POS_Z = 3'd2,
		REG_LIGHT_RED   = 3'd3,
		REG_LIGHT_GREEN = 3'd4,
		REG_LIGHT_BLUE  = 3'd5
	} reg_idx_t;

	// One shading request
	typedef struct packed {
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] point_z;
		logic signed [15:0] eye_x;
		logic signed [15:0] eye_y;
		logic signed [15:0] eye_z;
		logic signed [15:0] normal_x;
		logic signed [15:0] normal_y;
		logic signed [15:0] normal_z;
		logic [47:0]        material_color;
		logic [47:0]        material_weights;
		logic [SHINY_W-1:0] material_shininess;
	} in_item_t;

	// One shaded result
	typedef struct packed {
		logic [OUT_W-1:0] out_red;
		logic [OUT_W-1:0] out_green;
		logic [OUT_W-1:0] out_blue;
	} out_item_t;

	// Per-item data that rides along the light vector units
	typedef struct packed {
		logic [2:0]              neg;
		logic                    zero;
		logic [2:0][MAG_W-1:0]   mag;
		logic [2:0][EFF_W-1:0]   eff;
		logic [2:0][15:0]        eye;
		logic [2:0][15:0]        nrm;
		logic [47:0]             weights;
		logic [SHINY_W-1:0]      shiny;
	} side_t;

	// Per-item data that rides along the power unit
	typedef struct packed {
		logic                    spec_ok;
		logic [2:0][ACC_W-1:0]   acc;
		logic [15:0]             ws;
	} pw_side_t;

endpackage
`default_nettype wire

FILE: rtl/ppls_sqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on ppls_pkg for widths and the side data type.
`default_nettype none
module ppls_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        en,
	input  logic                        vld_i,
	input  logic [ppls_pkg::SUM_W-1:0]  rad,
	input  ppls_pkg::side_t             side_i,
	output logic                        vld_o,
	output logic [ppls_pkg::LEN_W-1:0]  root,
	output ppls_pkg::side_t             side_o
);
	import ppls_pkg::*;

	localparam int STEPS = SUM_W / 2;

	logic             vld_q  [STEPS];
	logic [SUM_W-1:0] rem_q  [STEPS];
	logic [SUM_W-1:0] res_q  [STEPS];
	side_t            side_q [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam logic [SUM_W-1:0] BIT = SUM_W'(1) << (2 * (STEPS - 1 - k));
		logic             vld_d;
		logic [SUM_W-1:0] rem_d;
		logic [SUM_W-1:0] res_d;
		side_t            side_d;
		logic [SUM_W:0]   trial;

		if (k == 0) begin : g_first
			assign vld_d  = vld_i;
			assign rem_d  = rad;
			assign res_d  = '0;
			assign side_d = side_i;
		end else begin : g_next
			assign vld_d  = vld_q[k-1];
			assign rem_d  = rem_q[k-1];
			assign res_d  = res_q[k-1];
			assign side_d = side_q[k-1];
		end

		assign trial = {1'b0, res_d} + {1'b0, BIT};

		// advance valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= vld_d;
			end
		end

		// try one root bit
		always_ff @(posedge clk) begin
			if (en) begin
				if ({1'b0, rem_d} >= trial) begin
					rem_q[k] <= rem_d - trial[SUM_W-1:0];
					res_q[k] <= (res_d >> 1) + BIT;
				end else begin
					rem_q[k] <= rem_d;
					res_q[k] <= res_d >> 1;
				end
				side_q[k] <= side_d;
			end
		end
	end

	assign vld_o  = vld_q[STEPS-1];
	assign root   = res_q[STEPS-1][LEN_W-1:0];
	assign side_o = side_q[STEPS-1];

endmodule
`default_nettype wire

FILE: rtl/ppls_div.sv
// Pipelined restoring divider, three lanes over one shared divisor,
// one quotient bit per stage. Depends on ppls_pkg.
`default_nettype none
module ppls_div #(
	parameter int CF = 14
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  en,
	input  logic                                  vld_i,
	input  logic [2:0][ppls_pkg::LEN_W+CF-1:0]    num,
	input  logic [ppls_pkg::LEN_W-1:0]            den,
	input  ppls_pkg::side_t                       side_i,
	output logic                                  vld_o,
	output logic [2:0][CF:0]                      quo,
	output ppls_pkg::side_t                       side_o
);
	import ppls_pkg::*;

	localparam int NW    = LEN_W + CF;
	localparam int STEPS = CF + 1;

	logic                  vld_q  [STEPS];
	logic [2:0][NW-1:0]    rem_q  [STEPS];
	logic [LEN_W-1:0]      den_q  [STEPS];
	logic [2:0][CF:0]      quo_q  [STEPS];
	side_t                 side_q [STEPS];

	for (genvar j = 0; j < STEPS; j++) begin : g_step
		localparam int K = CF - j;
		logic                vld_d;
		logic [2:0][NW-1:0]  rem_d;
		logic [LEN_W-1:0]    den_d;
		logic [2:0][CF:0]    quo_d;
		side_t               side_d;
		logic [NW-1:0]       dsh;

		if (j == 0) begin : g_first
			assign vld_d  = vld_i;
			assign rem_d  = num;
			assign den_d  = den;
			assign quo_d  = '0;
			assign side_d = side_i;
		end else begin : g_next
			assign vld_d  = vld_q[j-1];
			assign rem_d  = rem_q[j-1];
			assign den_d  = den_q[j-1];
			assign quo_d  = quo_q[j-1];
			assign side_d = side_q[j-1];
		end

		assign dsh = NW'(den_d) << K;

		// advance valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[j] <= 1'b0;
			end else if (en) begin
				vld_q[j] <= vld_d;
			end
		end

		// subtract the shifted divisor where it fits
		always_ff @(posedge clk) begin
			if (en) begin
				for (int i = 0; i < 3; i++) begin
					if (rem_d[i] >= dsh) begin
						rem_q[j][i] <= rem_d[i] - dsh;
						quo_q[j][i] <= quo_d[i] | ((CF+1)'(1) << K);
					end else begin
						rem_q[j][i] <= rem_d[i];
						quo_q[j][i] <= quo_d[i];
					end
				end
				den_q[j]  <= den_d;
				side_q[j] <= side_d;
			end
		end
	end

	assign vld_o  = vld_q[STEPS-1];
	assign quo    = quo_q[STEPS-1];
	assign side_o = side_q[STEPS-1];

endmodule
`default_nettype wire

FILE: rtl/ppls_pow.sv
// Pipelined square-and-multiply power, one exponent bit per stage,
// lowest bit first, every product rounded. Depends on ppls_pkg.
`default_nettype none
module ppls_pow #(
	parameter int CF = 14
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              vld_i,
	input  logic [CF:0]                       base,
	input  logic [ppls_pkg::SHINY_W-1:0]      shiny,
	input  ppls_pkg::pw_side_t                side_i,
	output logic                              vld_o,
	output logic [CF:0]                       pw,
	output ppls_pkg::pw_side_t                side_o
);
	import ppls_pkg::*;

	localparam int STEPS = SHINY_W;
	localparam int PW    = 2 * CF + 2;
	localparam logic [PW-1:0] HALF = PW'(1) << (CF - 1);
	localparam logic [CF:0]   ONE  = (CF+1)'(1) << CF;

	logic                vld_q   [STEPS];
	logic [CF:0]         base_q  [STEPS];
	logic [CF:0]         pw_q    [STEPS];
	logic [SHINY_W-1:0]  shiny_q [STEPS];
	pw_side_t            side_q  [STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		logic               vld_d;
		logic [CF:0]        base_d;
		logic [CF:0]        pw_d;
		logic [SHINY_W-1:0] shiny_d;
		pw_side_t           side_d;
		logic [PW-1:0]      sq_p;
		logic [PW-1:0]      mul_p;

		if (k == 0) begin : g_first
			assign vld_d   = vld_i;
			assign base_d  = base;
			assign pw_d    = ONE;
			assign shiny_d = shiny;
			assign side_d  = side_i;
		end else begin : g_next
			assign vld_d   = vld_q[k-1];
			assign base_d  = base_q[k-1];
			assign pw_d    = pw_q[k-1];
			assign shiny_d = shiny_q[k-1];
			assign side_d  = side_q[k-1];
		end

		assign sq_p  = PW'(base_d) * PW'(base_d);
		assign mul_p = PW'(pw_d) * PW'(base_d);

		// advance valid
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en) begin
				vld_q[k] <= vld_d;
			end
		end

		// square the base, multiply in where the exponent bit is set
		always_ff @(posedge clk) begin
			if (en) begin
				base_q[k] <= (CF+1)'((sq_p + HALF) >> CF);
				if (shiny_d[k]) begin
					pw_q[k] <= (CF+1)'((mul_p + HALF) >> CF);
				end else begin
					pw_q[k] <= pw_d;
				end
				shiny_q[k] <= shiny_d;
				side_q[k]  <= side_d;
			end
		end
	end

	assign vld_o  = vld_q[STEPS-1];
	assign pw     = pw_q[STEPS-1];
	assign side_o = side_q[STEPS-1];

endmodule
`default_nettype wire

FILE: rtl/phong_point_light_shader_core.sv
// Phong point light shader: top level with configuration registers and pipeline.
// Depends on ppls_pkg, ppls_sqrt, ppls_div and ppls_pow.
//
// Usage:
// A shading request (hit point, eye vector, normal, material) enters on the
// item channel; one shaded color leaves on the result channel per request.
// Both channels use valid/stall: a transfer happens on a clock edge with valid
// high and stall low. The user must write the light position and intensity
// through cfg_we/cfg_idx/cfg_data only while no request is in flight; the
// block does not enforce it. Throughput is one request per cycle unless stalled.
// The 31-stage square root and COLOR_FRAC_BITS+1 stage divider lie on the light
// vector path, the 10-stage power unit on the specular path.
// The whole pipeline advances together: while a result waits under stall the
// pipeline holds and item_stall is raised, so nothing is lost or repeated.
// Reset clears all valid bits and sets the light to the origin with unit
// intensity per channel.
`default_nettype none
module phong_point_light_shader_core #(
	parameter int COLOR_FRAC_BITS = 14
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  ppls_pkg::in_item_t    item,
	output logic                  result_valid,
	input  logic                  result_stall,
	output ppls_pkg::out_item_t   result,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_idx,
	input  logic [31:0]           cfg_data
);
	import ppls_pkg::*;

	localparam int CF     = COLOR_FRAC_BITS;
	localparam int ONE    = 1 << CF;
	localparam int HALF   = 1 << (CF - 1);
	localparam int NW     = LEN_W + CF;
	localparam int LW     = CF + 2;
	localparam int PLN_W  = LW + 16;
	localparam int DW     = LW + 18;
	localparam int M_W    = DW + 16;
	localparam int RW     = 35 - CF;
	localparam int Q_W    = RW + 16;
	localparam int RDE_W  = RW + 18;
	localparam int LR_W   = 18;
	localparam int SDP_W  = 16 + LR_W;
	localparam int SD_W   = SDP_W - CF;
	localparam int DP_W   = EFF_W + SD_W;
	localparam int AP_W   = EFF_W + 16;
	localparam int AMB_W  = AP_W + 1 - CF;
	localparam int SSP_W  = 16 + CF + 1;
	localparam int SS_W   = 17;
	localparam int SPP_W  = 16 + SS_W;
	localparam int SPEC_W = SPP_W - INTEN_FRAC + 1;
	localparam logic [OUT_W-1:0] TOP = (CF >= OUT_W) ? {OUT_W{1'b1}} : OUT_W'(ONE);

	// Rounded arithmetic right shift, half away from zero
	function automatic logic signed [63:0] rsh_s(input logic signed [63:0] v, input int s);
		logic signed [63:0] h;
		h = 64'sd1 <<< (s - 1);
		if (v >= 0) begin
			return (v + h) >>> s;
		end
		return -((-v + h) >>> s);
	endfunction

	logic adv;

	// Configuration registers
	logic signed [31:0] lpos_q [3];
	logic [2:0][15:0]   inten_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lpos_q[0] <= '0;
			lpos_q[1] <= '0;
			lpos_q[2] <= '0;
			inten_q   <= {3{16'd4096}};
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_LIGHT_POS_X: lpos_q[0]  <= cfg_data;
				REG_LIGHT_POS_Y: lpos_q[1]  <= cfg_data;
				REG_LIGHT_POS_Z: lpos_q[2]  <= cfg_data;
				REG_LIGHT_RED:   inten_q[0] <= cfg_data[15:0];
				REG_LIGHT_GREEN: inten_q[1] <= cfg_data[15:0];
				REG_LIGHT_BLUE:  inten_q[2] <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// Stall everything while the result register holds an untaken result
	assign adv        = !(result_valid && result_stall);
	assign item_stall = !adv;

	// Stage 1: light vector components, effective color
	logic signed [31:0] pt [3];
	logic [32:0]        mag_d [3];
	logic [2:0]         neg_d;
	logic [2:0][EFF_W-1:0] eff_d;
	logic               v_s1;
	logic [32:0]        mag_s1 [3];
	side_t              side_s1;

	assign pt[0] = item.point_x;
	assign pt[1] = item.point_y;
	assign pt[2] = item.point_z;

	always_comb begin
		logic signed [32:0] d;
		logic [31:0]        p;
		for (int i = 0; i < 3; i++) begin
			d        = 33'(lpos_q[i]) - 33'(pt[i]);
			neg_d[i] = d[32];
			mag_d[i] = d[32] ? 33'(-d) : 33'(d);
			p        = 32'(item.material_color[16*i +: 16]) * 32'(inten_q[i]);
			eff_d[i] = EFF_W'((33'(p) + 33'd2048) >> INTEN_FRAC);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1          <= mag_d;
			side_s1.neg     <= neg_d;
			side_s1.zero    <= 1'b0;
			side_s1.mag     <= '0;
			side_s1.eff     <= eff_d;
			side_s1.eye     <= {item.eye_z, item.eye_y, item.eye_x};
			side_s1.nrm     <= {item.normal_z, item.normal_y, item.normal_x};
			side_s1.weights <= item.material_weights;
			side_s1.shiny   <= item.material_shininess;
		end
	end

	// Stage 2: scale magnitudes so the largest lies in [2^29, 2^30)
	logic [32:0]  mx;
	logic [5:0]   msb;
	logic [2:0][MAG_W-1:0] nmag;
	side_t        side_d2;
	logic         v_s2;
	side_t        side_s2;

	always_comb begin
		mx = mag_s1[0];
		if (mag_s1[1] > mx) mx = mag_s1[1];
		if (mag_s1[2] > mx) mx = mag_s1[2];
		msb = '0;
		for (int b = 0; b < 33; b++) begin
			if (mx[b]) msb = 6'(b);
		end
		for (int i = 0; i < 3; i++) begin
			if (msb > 6'(MAG_W - 1)) begin
				nmag[i] = MAG_W'(mag_s1[i] >> (msb - 6'(MAG_W - 1)));
			end else begin
				nmag[i] = MAG_W'(mag_s1[i] << (6'(MAG_W - 1) - msb));
			end
		end
		side_d2      = side_s1;
		side_d2.mag  = nmag;
		side_d2.zero = (mx == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s2 <= side_d2;
		end
	end

	// Stage 3: squares
	logic [2*MAG_W-1:0] sq_s3 [3];
	logic               v_s3;
	side_t              side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				sq_s3[i] <= (2*MAG_W)'(side_s2.mag[i]) * (2*MAG_W)'(side_s2.mag[i]);
			end
			side_s3 <= side_s2;
		end
	end

	// Stage 4: sum of squares
	logic [SUM_W-1:0] sum_s4;
	logic             v_s4;
	side_t            side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (adv) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sum_s4  <= SUM_W'(sq_s3[0]) + SUM_W'(sq_s3[1]) + SUM_W'(sq_s3[2]);
			side_s4 <= side_s3;
		end
	end

	// Vector length
	logic             sq_vld;
	logic [LEN_W-1:0] len;
	side_t            sq_side;

	ppls_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (v_s4),
		.rad    (sum_s4),
		.side_i (side_s4),
		.vld_o  (sq_vld),
		.root   (len),
		.side_o (sq_side)
	);

	// Stage 5: rounded dividends
	logic [2:0][NW-1:0] num_s5;
	logic [LEN_W-1:0]   den_s5;
	logic               v_s5;
	side_t              side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (adv) begin
			v_s5 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				num_s5[i] <= (NW'(sq_side.mag[i]) << CF) + NW'(len >> 1);
			end
			den_s5  <= len;
			side_s5 <= sq_side;
		end
	end

	// Unit light vector components
	logic             dv_vld;
	logic [2:0][CF:0] quo;
	side_t            dv_side;

	ppls_div #(.CF(CF)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (v_s5),
		.num    (num_s5),
		.den    (den_s5),
		.side_i (side_s5),
		.vld_o  (dv_vld),
		.quo    (quo),
		.side_o (dv_side)
	);

	// Stage 6: apply signs, zero vector when light sits on the hit point
	logic signed [LW-1:0] l_s6 [3];
	logic                 v_s6;
	side_t                side_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (adv) begin
			v_s6 <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				if (dv_side.zero) begin
					l_s6[i] <= '0;
				end else if (dv_side.neg[i]) begin
					l_s6[i] <= -LW'(quo[i]);
				end else begin
					l_s6[i] <= LW'(quo[i]);
				end
			end
			side_s6 <= dv_side;
		end
	end

	// Stage 7: light times normal products
	logic signed [PLN_W-1:0] pln_s7 [3];
	logic signed [LW-1:0]    l_s7 [3];
	logic                    v_s7;
	side_t                   side_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
		end else if (adv) begin
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				pln_s7[i] <= PLN_W'(l_s6[i]) * PLN_W'($signed(side_s6.nrm[i]));
			end
			l_s7    <= l_s6;
			side_s7 <= side_s6;
		end
	end

	// Stage 8: light dot normal
	logic signed [DW-1:0] ldn_s8;
	logic signed [LW-1:0] l_s8 [3];
	logic                 v_s8;
	side_t                side_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (adv) begin
			v_s8 <= v_s7;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ldn_s8  <= DW'(pln_s7[0]) + DW'(pln_s7[1]) + DW'(pln_s7[2]);
			l_s8    <= l_s7;
			side_s8 <= side_s7;
		end
	end

	// Stage 9: normal scaled by the dot, rounded dot, lit flag
	logic signed [M_W-1:0] m_s9 [3];
	logic [LR_W-1:0]       ldnr_s9;
	logic                  lit_s9;
	logic signed [LW-1:0]  l_s9 [3];
	logic                  v_s9;
	side_t                 side_s9;
	logic signed [DW:0]    ldn_rnd;

	assign ldn_rnd = ((DW+1)'(ldn_s8) + (DW+1)'(HALF)) >>> CF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (adv) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				m_s9[i] <= M_W'($signed(side_s8.nrm[i])) * M_W'(ldn_s8);
			end
			ldnr_s9 <= ldn_rnd[LR_W-1:0];
			lit_s9  <= !ldn_s8[DW-1];
			l_s9    <= l_s8;
			side_s9 <= side_s8;
		end
	end

	// Stage 10: reflected light, diffuse and ambient products
	logic signed [RW-1:0] r_s10 [3];
	logic [SDP_W-1:0]     sdp_s10;
	logic [AP_W-1:0]      ap_s10 [3];
	logic                 lit_s10;
	logic                 v_s10;
	side_t                side_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (adv) begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				r_s10[i]  <= RW'(rsh_s(64'(m_s9[i]) <<< 1, 2 * CF) - 64'(l_s9[i]));
				ap_s10[i] <= AP_W'(side_s9.eff[i]) * AP_W'(side_s9.weights[15:0]);
			end
			sdp_s10  <= SDP_W'(side_s9.weights[31:16]) * SDP_W'(ldnr_s9);
			lit_s10  <= lit_s9;
			side_s10 <= side_s9;
		end
	end

	// Stage 11: reflection times eye products, round diffuse weight and ambient
	logic signed [Q_W-1:0] q_s11 [3];
	logic [SD_W-1:0]       sd_s11;
	logic [AMB_W-1:0]      amb_s11 [3];
	logic                  lit_s11;
	logic                  v_s11;
	side_t                 side_s11;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s11 <= 1'b0;
		end else if (adv) begin
			v_s11 <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				q_s11[i]   <= Q_W'(r_s10[i]) * Q_W'($signed(side_s10.eye[i]));
				amb_s11[i] <= AMB_W'(((AP_W+1)'(ap_s10[i]) + (AP_W+1)'(HALF)) >> CF);
			end
			sd_s11   <= SD_W'(((SDP_W+1)'(sdp_s10) + (SDP_W+1)'(HALF)) >> CF);
			lit_s11  <= lit_s10;
			side_s11 <= side_s10;
		end
	end

	// Stage 12: reflection dot eye, diffuse products
	logic signed [RDE_W-1:0] rde_s12;
	logic [DP_W-1:0]         dp_s12 [3];
	logic [AMB_W-1:0]        amb_s12 [3];
	logic                    lit_s12;
	logic                    v_s12;
	side_t                   side_s12;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s12 <= 1'b0;
		end else if (adv) begin
			v_s12 <= v_s11;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			rde_s12 <= RDE_W'(q_s11[0]) + RDE_W'(q_s11[1]) + RDE_W'(q_s11[2]);
			for (int i = 0; i < 3; i++) begin
				dp_s12[i] <= DP_W'(side_s11.eff[i]) * DP_W'(sd_s11);
			end
			amb_s12  <= amb_s11;
			lit_s12  <= lit_s11;
			side_s12 <= side_s11;
		end
	end

	// Stage 13: power base, ambient plus diffuse
	logic signed [RDE_W:0] base_rnd;
	logic [CF:0]           base_s13;
	logic [SHINY_W-1:0]    shiny_s13;
	pw_side_t              pws_s13;
	logic                  v_s13;

	assign base_rnd = ((RDE_W+1)'(rde_s12) + (RDE_W+1)'(HALF)) >>> CF;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s13 <= 1'b0;
		end else if (adv) begin
			v_s13 <= v_s12;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (base_rnd > (RDE_W+1)'(ONE)) begin
				base_s13 <= (CF+1)'(ONE);
			end else begin
				base_s13 <= base_rnd[CF:0];
			end
			for (int i = 0; i < 3; i++) begin
				if (lit_s12) begin
					pws_s13.acc[i] <= ACC_W'(amb_s12[i])
						+ ACC_W'(((DP_W+1)'(dp_s12[i]) + (DP_W+1)'(HALF)) >> CF);
				end else begin
					pws_s13.acc[i] <= ACC_W'(amb_s12[i]);
				end
			end
			pws_s13.spec_ok <= lit_s12 && (rde_s12 > 0);
			pws_s13.ws      <= side_s12.weights[47:32];
			shiny_s13       <= side_s12.shiny;
		end
	end

	// Specular power
	logic        pw_vld;
	logic [CF:0] pw;
	pw_side_t    pw_side;

	ppls_pow #(.CF(CF)) u_pow (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (adv),
		.vld_i  (v_s13),
		.base   (base_s13),
		.shiny  (shiny_s13),
		.side_i (pws_s13),
		.vld_o  (pw_vld),
		.pw     (pw),
		.side_o (pw_side)
	);

	// Stage 14: specular weight times power
	logic [SSP_W-1:0] ssp_s14;
	pw_side_t         pws_s14;
	logic             v_s14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s14 <= 1'b0;
		end else if (adv) begin
			v_s14 <= pw_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ssp_s14 <= SSP_W'(pw_side.ws) * SSP_W'(pw);
			pws_s14 <= pw_side;
		end
	end

	// Stage 15: round specular scale
	logic [SS_W-1:0] ss_s15;
	pw_side_t        pws_s15;
	logic            v_s15;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s15 <= 1'b0;
		end else if (adv) begin
			v_s15 <= v_s14;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ss_s15  <= SS_W'(((SSP_W+1)'(ssp_s14) + (SSP_W+1)'(HALF)) >> CF);
			pws_s15 <= pws_s14;
		end
	end

	// Stage 16: light intensity times specular scale
	logic [SPP_W-1:0] spp_s16 [3];
	pw_side_t         pws_s16;
	logic             v_s16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s16 <= 1'b0;
		end else if (adv) begin
			v_s16 <= v_s15;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				spp_s16[i] <= SPP_W'(inten_q[i]) * SPP_W'(ss_s15);
			end
			pws_s16 <= pws_s15;
		end
	end

	// Stage 17: add specular, clamp, hold in the result register
	logic [OUT_W-1:0] chan [3];

	always_comb begin
		logic [SPEC_W-1:0] spec;
		logic [ACC_W:0]    tot;
		for (int i = 0; i < 3; i++) begin
			if (pws_s16.spec_ok) begin
				spec = SPEC_W'(((SPP_W+1)'(spp_s16[i]) + (SPP_W+1)'(2048)) >> INTEN_FRAC);
			end else begin
				spec = '0;
			end
			tot = (ACC_W+1)'(pws_s16.acc[i]) + (ACC_W+1)'(spec);
			if (tot > (ACC_W+1)'(TOP)) begin
				chan[i] = TOP;
			end else begin
				chan[i] = tot[OUT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (adv) begin
			result_valid <= v_s16;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result.out_red   <= chan[0];
			result.out_green <= chan[1];
			result.out_blue  <= chan[2];
		end
	end

endmodule
`default_nettype wire
